// ===== design/assert_macros.svh =====
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ght_pkg.sv =====
// Types and constants of the generational handle table.
`default_nettype none

package ght_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_BITS  = 8;
    localparam int GEN_BITS   = 16;
    localparam int PAY_BITS   = 32;
    localparam int COUNT_BITS = 9;
    localparam int CMD_BITS   = 3;
    localparam int STAT_BITS  = 2;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [GEN_BITS-1:0]   t_gen;
    typedef logic [PAY_BITS-1:0]   t_pay;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [CMD_BITS-1:0]   t_cmd;
    typedef logic [STAT_BITS-1:0]  t_status;

    localparam t_cmd CMD_ADD    = 3'd0;
    localparam t_cmd CMD_LOOKUP = 3'd1;
    localparam t_cmd CMD_UPDATE = 3'd2;
    localparam t_cmd CMD_REMOVE = 3'd3;
    localparam t_cmd CMD_CLEAR  = 3'd4;

    localparam t_status STAT_OK      = 2'd0;
    localparam t_status STAT_FULL    = 2'd1;
    localparam t_status STAT_STALE   = 2'd2;
    localparam t_status STAT_NO_USED = 2'd3;

    localparam t_gen   GEN_RESET = 16'd1;
    localparam t_count MAX_COUNT = 9'd256;

    typedef struct packed {
        t_cmd  cmd;
        t_slot slot_index;
        t_gen  generation;
        t_pay  payload;
    } t_in_word;

    typedef struct packed {
        t_status status;
        t_slot   handle_index;
        t_gen    handle_generation;
        t_pay    found_payload;
        t_count  used_count;
    } t_out_word;

    typedef struct packed {
        logic  active;
        t_slot link;
        t_gen  gen;
    } t_meta;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_ctl;

endpackage

`default_nettype wire

// ===== design/generational_handle_table.sv =====
// Top level of the generational handle table.
//
// Input channel: i_valid / o_stall carry one command word (add, lookup,
// update, remove, clear) with a handle and a payload. Output channel:
// o_valid / i_stall carry one result word per command: status, handle,
// found payload and the number of active slots afterwards.
// A word is accepted in ST_IDLE with a registered read of the slot RAMs
// and executed with the write-back in ST_EXEC, once the output register
// is free; the result is shown on o_valid from then on. No new word is
// taken until the last one has executed. Clear runs the same way: its
// per-slot valid bits return links and generations to reset at once.
// While a result waits under i_stall, the next word is still accepted and
// read; its execution waits until the output register is free.
// Reset is synchronous, active low: empty table, free chain 0,1,2..., all
// generations 1, no result pending. Payload RAM contents are kept.
`default_nettype none

module generational_handle_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire ght_pkg::t_in_word  i_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output ght_pkg::t_out_word      o_word
);

    ght_pkg::t_ctl ctl;

    ght_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    ght_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_word  (i_word),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire

// ===== design/ght_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ght_ctrl.sv =====
// Sequencer of the handle table: accept, execute, hold the result word.
`default_nettype none

module ght_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ght_pkg::t_ctl      o_ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_take;

    always_comb begin
        out_take     = r_out_valid && !i_stall;
        o_ctl.accept = (r_state == ST_IDLE) && i_valid;
        o_ctl.exec   = (r_state == ST_EXEC) && (!r_out_valid || out_take);
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_ctl.accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (o_ctl.exec) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/ght_datapath.sv =====
// Slot storage, free chain and result register of the handle table.
`default_nettype none

module ght_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ght_pkg::t_ctl     i_ctl,
    input  wire ght_pkg::t_in_word i_word,
    output ght_pkg::t_out_word     o_word
);

    ght_pkg::t_cmd      r_cmd;
    ght_pkg::t_slot     r_addr;
    ght_pkg::t_gen      r_gen;
    ght_pkg::t_pay      r_pay;
    ght_pkg::t_slot     r_free_head;
    ght_pkg::t_slot     n_free_head;
    ght_pkg::t_count    r_count;
    ght_pkg::t_count    n_count;
    logic [ght_pkg::SLOTS-1:0] r_touched;
    logic [ght_pkg::SLOTS-1:0] n_touched;
    ght_pkg::t_out_word r_out;
    ght_pkg::t_out_word n_out;

    ght_pkg::t_slot     rd_addr;
    ght_pkg::t_meta     meta_rdata;
    ght_pkg::t_meta     meta;
    ght_pkg::t_meta     meta_wdata;
    logic               meta_we;
    ght_pkg::t_pay      pay_rdata;
    logic               pay_we;
    ght_pkg::t_gen      next_gen;
    logic               hit;

    assign rd_addr = (i_word.cmd == ght_pkg::CMD_ADD) ? r_free_head : i_word.slot_index;

    ght_ram #(
        .WIDTH ($bits(ght_pkg::t_meta)),
        .DEPTH (ght_pkg::SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_addr),
        .i_wdata (meta_wdata),
        .i_re    (i_ctl.accept),
        .i_raddr (rd_addr),
        .o_rdata (meta_rdata)
    );

    ght_ram #(
        .WIDTH (ght_pkg::PAY_BITS),
        .DEPTH (ght_pkg::SLOTS)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (r_addr),
        .i_wdata (r_pay),
        .i_re    (i_ctl.accept),
        .i_raddr (rd_addr),
        .o_rdata (pay_rdata)
    );

    always_comb begin
        if (r_touched[r_addr]) begin
            meta = meta_rdata;
        end else begin
            meta.active = 1'b0;
            meta.link   = ght_pkg::t_slot'(r_addr + 1'b1);
            meta.gen    = ght_pkg::GEN_RESET;
        end
        next_gen = ght_pkg::t_gen'(meta.gen + 1'b1);
        if (next_gen == '0) begin
            next_gen = ght_pkg::GEN_RESET;
        end
        hit = meta.active && (meta.gen == r_gen);

        n_free_head                = r_free_head;
        n_count                    = r_count;
        n_touched                  = r_touched;
        meta_we                    = 1'b0;
        meta_wdata                 = meta;
        pay_we                     = 1'b0;
        n_out.status               = ght_pkg::STAT_OK;
        n_out.handle_index         = r_addr;
        n_out.handle_generation    = '0;
        n_out.found_payload        = '0;

        if (i_ctl.exec) begin
            case (r_cmd)
                ght_pkg::CMD_ADD: begin
                    n_out.handle_index = '0;
                    if (r_count == ght_pkg::MAX_COUNT) begin
                        n_out.status = ght_pkg::STAT_FULL;
                    end else begin
                        n_free_head             = meta.link;
                        meta_we                 = 1'b1;
                        meta_wdata.active       = 1'b1;
                        meta_wdata.link         = '0;
                        meta_wdata.gen          = next_gen;
                        n_touched[r_addr]       = 1'b1;
                        pay_we                  = 1'b1;
                        n_count                 = ght_pkg::t_count'(r_count + 1'b1);
                        n_out.handle_index      = r_addr;
                        n_out.handle_generation = next_gen;
                    end
                end
                ght_pkg::CMD_LOOKUP: begin
                    if (hit) begin
                        n_out.found_payload = pay_rdata;
                    end else begin
                        n_out.status = ght_pkg::STAT_STALE;
                    end
                end
                ght_pkg::CMD_UPDATE: begin
                    if (hit) begin
                        pay_we = 1'b1;
                    end else begin
                        n_out.status = ght_pkg::STAT_STALE;
                    end
                end
                ght_pkg::CMD_REMOVE: begin
                    if (r_count == '0) begin
                        n_out.status = ght_pkg::STAT_NO_USED;
                    end else if (!hit) begin
                        n_out.status = ght_pkg::STAT_STALE;
                    end else begin
                        meta_we           = 1'b1;
                        meta_wdata.active = 1'b0;
                        meta_wdata.link   = r_free_head;
                        n_touched[r_addr] = 1'b1;
                        n_free_head       = r_addr;
                        n_count           = ght_pkg::t_count'(r_count - 1'b1);
                    end
                end
                ght_pkg::CMD_CLEAR: begin
                    n_touched   = '0;
                    n_free_head = '0;
                    n_count     = '0;
                end
                default: begin
                end
            endcase
        end
        n_out.used_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_count     <= '0;
            r_touched   <= '0;
        end else begin
            r_free_head <= n_free_head;
            r_count     <= n_count;
            r_touched   <= n_touched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd  <= i_word.cmd;
            r_addr <= rd_addr;
            r_gen  <= i_word.generation;
            r_pay  <= i_word.payload;
        end
        if (i_ctl.exec) begin
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

`default_nettype wire

// ===== design/ght_checker.sv =====
// Port-level checks of the handle table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ght_port_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire ght_pkg::t_in_word  i_word,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire ght_pkg::t_out_word o_word
);

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "result or stall after reset")

    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_word), "stalled result word changed")

    `ASSERT_SYNC(a_one_at_a_time, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "word accepted while busy")

    `ASSERT_SYNC(a_count_range, i_clk, i_rst_n, !(o_valid && (o_word.used_count > ght_pkg::MAX_COUNT)), "used count beyond table size")

    `ASSERT_SYNC(a_gen_only_ok, i_clk, i_rst_n, o_valid && (o_word.handle_generation != '0) |-> o_word.status == ght_pkg::STAT_OK, "generation given with failure status")

endmodule

bind generational_handle_table ght_port_checker u_ght_checker (.*);

`default_nettype wire

// ===== tb/ght_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts and compares every result word of the handle table.
module ght_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire logic               i_cmd_stall,
    input  wire ght_pkg::t_in_word  i_cmd_word,
    input  wire logic               i_res_valid,
    input  wire logic               i_res_stall,
    input  wire ght_pkg::t_out_word i_res_word,
    output int                      o_fail_count,
    output int                      o_pending
);
    import ght_pkg::*;

    t_slot     link_mem [SLOTS];
    t_gen      gen_mem  [SLOTS];
    logic      live_mem [SLOTS];
    t_pay      pay_mem  [SLOTS];
    t_slot     free_slot;
    t_count    live_total;
    t_out_word result_q [$];
    t_out_word want;
    int        fails = 0;

    function automatic void rebuild_table();
        for (int k = 0; k < SLOTS; k++) begin
            link_mem[k] = t_slot'((k + 1) % SLOTS);
            gen_mem[k]  = GEN_RESET;
            live_mem[k] = 1'b0;
        end
        free_slot  = '0;
        live_total = '0;
    endfunction

    function automatic logic handle_ok(t_slot idx, t_gen gen);
        return live_mem[idx] && (gen_mem[idx] == gen);
    endfunction

    function automatic t_out_word execute_command(t_in_word w);
        t_out_word r;
        t_slot     s;
        t_gen      g;
        r = '0;
        r.status = STAT_OK;
        r.handle_index = w.slot_index;
        case (w.cmd)
            CMD_ADD: begin
                r.handle_index = '0;
                if (live_total >= MAX_COUNT) begin
                    r.status = STAT_FULL;
                end else begin
                    s = free_slot;
                    g = gen_mem[s] + 1'b1;
                    if (g == '0) begin
                        g = GEN_RESET;
                    end
                    free_slot   = link_mem[s];
                    link_mem[s] = '0;
                    gen_mem[s]  = g;
                    live_mem[s] = 1'b1;
                    pay_mem[s]  = w.payload;
                    live_total  = live_total + 1'b1;
                    r.handle_index      = s;
                    r.handle_generation = g;
                end
            end
            CMD_LOOKUP: begin
                if (handle_ok(w.slot_index, w.generation)) begin
                    r.found_payload = pay_mem[w.slot_index];
                end else begin
                    r.status = STAT_STALE;
                end
            end
            CMD_UPDATE: begin
                if (handle_ok(w.slot_index, w.generation)) begin
                    pay_mem[w.slot_index] = w.payload;
                end else begin
                    r.status = STAT_STALE;
                end
            end
            CMD_REMOVE: begin
                if (live_total == '0) begin
                    r.status = STAT_NO_USED;
                end else if (!handle_ok(w.slot_index, w.generation)) begin
                    r.status = STAT_STALE;
                end else begin
                    link_mem[w.slot_index] = free_slot;
                    live_mem[w.slot_index] = 1'b0;
                    free_slot  = w.slot_index;
                    live_total = live_total - 1'b1;
                end
            end
            CMD_CLEAR: begin
                rebuild_table();
            end
            default: begin
            end
        endcase
        r.used_count = live_total;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
        if (got !== exp) begin
            $error("%s: expected %0h, got %0h", name, exp, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rebuild_table();
            result_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (result_q.size() == 0) begin
                    $error("result word with no command waiting: %0h", i_res_word);
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    check_field("status", want.status, i_res_word.status);
                    check_field("handle_index", want.handle_index,
                                i_res_word.handle_index);
                    check_field("handle_generation", want.handle_generation,
                                i_res_word.handle_generation);
                    check_field("found_payload", want.found_payload,
                                i_res_word.found_payload);
                    check_field("used_count", want.used_count, i_res_word.used_count);
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                result_q.push_back(execute_command(i_cmd_word));
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the handle table testbench: clock, reset, command stimulus and verdict.
module testbench;
    import ght_pkg::*;

    localparam int   HALF_PERIOD  = 5;
    localparam int   CYCLE_LIMIT  = 2_000_000;
    localparam t_cmd CMD_SPARE_LO = 3'd5;
    localparam t_cmd CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        t_slot idx;
        t_gen  gen;
    } t_handle;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_word  i_word  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_word;

    int          fail_count;
    int          pending;
    int          full_seen  = 0;
    int          empty_seen = 0;
    int          stall_hold = 0;
    int          stall_len;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;
    t_handle     live_q [$];

    generational_handle_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    ght_checker ght_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_stall  (o_stall),
        .i_cmd_word   (i_word),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res_word   (o_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Collect handles given out by add, and count full and empty replies.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (o_word.status == STAT_FULL) full_seen++;
            if (o_word.status == STAT_NO_USED) empty_seen++;
            if (o_word.status == STAT_OK && o_word.handle_generation != '0) begin
                live_q.push_back({o_word.handle_index, o_word.handle_generation});
            end
        end
    end

    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            stall_hold = 0;
            i_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else if (i_stall) begin
            i_stall <= 1'b0;
            stall_hold = $urandom_range(0, 12);
        end else begin
            stall_len = pick_gap();
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                stall_hold = stall_len - 1;
            end
        end
    end

    task automatic send_word(input t_in_word w);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input t_cmd c, input t_slot s, input t_gen g, input t_pay p);
        t_in_word w;
        w.cmd        = c;
        w.slot_index = s;
        w.generation = g;
        w.payload    = p;
        send_word(w);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic t_in_word make_word(int add_pct, int remove_pct, bit allow_clear);
        t_in_word w;
        int       roll;
        int       pick;
        w.slot_index = t_slot'($urandom);
        w.generation = t_gen'($urandom);
        w.payload    = $urandom;
        roll = $urandom_range(0, 19);
        if (roll == 0) w.payload = '0;
        if (roll == 1) w.payload = '1;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            w.cmd = CMD_ADD;
        end else if (roll < add_pct + remove_pct) begin
            w.cmd = CMD_REMOVE;
        end else if (allow_clear && roll >= 98) begin
            w.cmd = CMD_CLEAR;
            live_q.delete();
        end else if (roll >= 95) begin
            w.cmd = t_cmd'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end else begin
            w.cmd = ($urandom_range(0, 1) != 0) ? CMD_LOOKUP : CMD_UPDATE;
        end
        if (w.cmd != CMD_ADD && w.cmd != CMD_CLEAR && live_q.size() > 0) begin
            roll = $urandom_range(0, 9);
            pick = $urandom_range(0, live_q.size() - 1);
            if (roll < 8) begin
                w.slot_index = live_q[pick].idx;
                w.generation = live_q[pick].gen;
                if (w.cmd == CMD_REMOVE) live_q.delete(pick);
            end else if (roll == 8) begin
                // near miss: right slot, one generation bit off
                w.slot_index = live_q[pick].idx;
                w.generation = live_q[pick].gen ^
                               (t_gen'(1) << $urandom_range(0, GEN_BITS - 1));
            end
        end
        return w;
    endfunction

    task automatic run_items(input int count, input int add_pct, input int remove_pct);
        repeat (count) send_word(make_word(add_pct, remove_pct, 1'b1));
    endtask

    initial begin
        int   target;
        t_gen burst_gen;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_fields(CMD_REMOVE, 8'd5, GEN_RESET, '0);
        send_fields(CMD_LOOKUP, 8'd0, GEN_RESET, '0);
        send_fields(CMD_ADD, 8'hFF, '1, '0);
        send_fields(CMD_ADD, 8'd0, '0, '1);
        send_fields(CMD_LOOKUP, 8'd0, 16'd2, '1);
        send_fields(CMD_LOOKUP, 8'd1, 16'd2, '0);
        send_fields(CMD_LOOKUP, 8'd1, '1, '0);
        send_fields(CMD_UPDATE, 8'd1, 16'd2, 32'hA5A5_5A5A);
        send_fields(CMD_UPDATE, 8'd1, '0, '1);
        send_fields(CMD_LOOKUP, 8'd1, 16'd2, '0);
        send_fields(CMD_REMOVE, 8'd0, 16'd3, '0);
        send_fields(CMD_REMOVE, 8'd0, 16'd2, '0);
        send_fields(CMD_LOOKUP, 8'd0, 16'd2, '0);
        send_fields(CMD_ADD, 8'd0, '0, 32'h1234_5678);
        send_fields(CMD_LOOKUP, 8'hFF, '1, '1);
        for (int k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++) begin
            send_fields(t_cmd'(k), '1, '1, '1);
        end
        send_fields(CMD_CLEAR, 8'h80, 16'h8000, 32'h8000_0000);
        send_fields(CMD_LOOKUP, 8'd0, 16'd3, '0);
        send_fields(CMD_ADD, 8'd0, '0, 32'hFFFF_0000);
        send_fields(CMD_REMOVE, 8'd0, 16'd2, '0);
        send_fields(CMD_REMOVE, 8'd0, 16'd2, '0);
        pause_until_drained();
        live_q.delete();

        run_items(15, 45, 25);
        calm = 1'b1;
        run_items(15, 45, 25);
        calm = 1'b0;
        run_items(15, 45, 25);

        // fill the table and keep knocking on it
        target = full_seen + 6;
        while (full_seen < target) send_word(make_word(90, 4, 1'b0));

        // drain it down to nothing active
        target = empty_seen + 4;
        while (empty_seen < target) send_word(make_word(4, 92, 1'b0));

        pause_until_drained();
        run_items(20, 40, 30);

        // cycle slot 0 through a run of generations
        pause_until_drained();
        send_fields(CMD_CLEAR, '0, '0, '0);
        calm = 1'b1;
        burst_gen = GEN_RESET;
        repeat (12) begin
            burst_gen = burst_gen + 1'b1;
            if (burst_gen == '0) burst_gen = GEN_RESET;
            send_fields(CMD_ADD, t_slot'($urandom), t_gen'($urandom), $urandom);
            send_fields(CMD_REMOVE, 8'd0, burst_gen, $urandom);
        end
        calm = 1'b0;

        pause_until_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
